// File: sv/rfwr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfwr_pkg
// Types and codes shared by the ring FIFO with remove: request and result
// payloads, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package rfwr_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_PUSH = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DATA_W-1:0]  popped;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic finish;
    logic srch_start;
    logic srch_rd;
    logic srch_next;
    logic mark_found;
    logic sh_rd;
    logic sh_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_remove;
    logic empty;
    logic match;
    logic last;
    logic at_head;
    logic slot_free;
  } sts_t;

endpackage : rfwr_pkg
`default_nettype wire

// File: sv/ring_fifo_with_remove.sv
`default_nettype none
// Push, pop, pop-push, clear: one request at a time; the head entry is read from
//   the entry RAM (registered read) on accept, then the result register is written.
// Remove: reads and compares each entry from the head until one matches, then
//   moves each older entry one place toward the tail; if none matches, all are read.
// Reset: pointers and count to zero, capacity to 64 (at most DEPTH); entries
//   are undefined until written. A capacity write also empties the FIFO.
// ----------------------------------------------------------------------------
// ring_fifo_with_remove
// Circular FIFO of 64-bit entries with push, pop, pop-push, ordered remove
// by value and clear; one result per request with status, data and count.
// ----------------------------------------------------------------------------
module ring_fifo_with_remove
  import rfwr_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_item_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  rfwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rfwr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule : ring_fifo_with_remove
`default_nettype wire

// File: sv/rfwr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfwr_ram
// Generic single-write, single-read RAM with registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module rfwr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : rfwr_ram
`default_nettype wire

// File: sv/rfwr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfwr_ctrl
// Sequencer for the ring FIFO: takes one request at a time, runs the search
// and shift walk of a remove, and finishes each request into the result slot.
// ----------------------------------------------------------------------------
module rfwr_ctrl
  import rfwr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SRD   = 3'd2;
  localparam logic [2:0] S_SCMP  = 3'd3;
  localparam logic [2:0] S_SHRD  = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_remove && !sts_i.empty) begin
          cmd_o.srch_start = 1'b1;
          state_d          = S_SRD;
        end else if (sts_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SRD: begin
        cmd_o.srch_rd = 1'b1;
        state_d       = S_SCMP;
      end
      S_SCMP: begin
        if (sts_i.match) begin
          cmd_o.mark_found = 1'b1;
          state_d          = S_SHRD;
        end else if (sts_i.last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.srch_next = 1'b1;
          state_d         = S_SRD;
        end
      end
      S_SHRD: begin
        // fetch the next older entry until the head is reached
        if (sts_i.at_head) begin
          state_d = S_FIN;
        end else begin
          cmd_o.sh_rd = 1'b1;
          state_d     = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SHRD;
      end
      S_FIN: begin
        if (sts_i.slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule : rfwr_ctrl
`default_nettype wire

// File: sv/rfwr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfwr_dp
// Datapath of the ring FIFO: pointers, fill count, capacity register,
// entry RAM, search/shift position and the result register.
// ----------------------------------------------------------------------------
module rfwr_dp
  import rfwr_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [COUNT_W-1:0]  cfg_data_i,
  input  wire cmd_t                cmd_i,
  output sts_t                     sts_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = ((PTR_W + 1) > COUNT_W) ? (PTR_W + 1) : COUNT_W;
  localparam logic [COUNT_W-1:0] DEPTH_C =
    COUNT_W'((DEPTH > 127) ? 127 : DEPTH);
  localparam logic [COUNT_W-1:0] CAP_RST =
    COUNT_W'((DEPTH < 64) ? DEPTH : 64);

  function automatic logic [COUNT_W-1:0] clamp_cap(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    if (c == '0) begin
      r = COUNT_W'(1);
    end else if (c > DEPTH_C) begin
      r = DEPTH_C;
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [COUNT_W-1:0] cap);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= CW'(cap)) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ret(input logic [PTR_W-1:0] p,
                                           input logic [COUNT_W-1:0] cap);
    logic [CW-1:0] n;
    n = (p == '0) ? (CW'(cap) - CW'(1)) : (CW'(p) - CW'(1));
    return n[PTR_W-1:0];
  endfunction

  logic [COUNT_W-1:0] cap_q, cap_d;
  logic [PTR_W-1:0]   rp_q, rp_d;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0]   pos_q, pos_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic               found_q, found_d;
  logic               out_valid_q, out_valid_d;
  logic [MODE_W-1:0]  mode_q;
  logic [DATA_W-1:0]  value_q;
  out_item_t          out_q;
  out_item_t          res;

  logic               push_we;
  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic [PTR_W-1:0]   pos_prev;

  assign pos_prev = ret(pos_q, cap_q);

  always_comb begin
    cap_d   = cap_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    cnt_d   = cnt_q;
    push_we = 1'b0;
    res     = '0;
    res.status = ST_OK;
    if (cfg_we_i) begin
      cap_d = clamp_cap(cfg_data_i);
      rp_d  = '0;
      wp_d  = '0;
      cnt_d = '0;
    end else if (cmd_i.finish) begin
      unique case (mode_q)
        MODE_PUSH: begin
          if (cnt_q >= cap_q) begin
            res.status = ST_FULL;
          end else begin
            push_we = 1'b1;
            wp_d    = adv(wp_q, cap_q);
            cnt_d   = cnt_q + COUNT_W'(1);
          end
        end
        MODE_POP: begin
          if (cnt_q == '0) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped = ram_rdata;
            rp_d       = adv(rp_q, cap_q);
            cnt_d      = cnt_q - COUNT_W'(1);
          end
        end
        MODE_POP_PUSH: begin
          push_we = 1'b1;
          wp_d    = adv(wp_q, cap_q);
          if (cnt_q == '0) begin
            res.status = ST_EMPTY;
            cnt_d      = cnt_q + COUNT_W'(1);
          end else begin
            res.popped = ram_rdata;
            rp_d       = adv(rp_q, cap_q);
          end
        end
        MODE_REMOVE: begin
          if (cnt_q == '0) begin
            res.status = ST_EMPTY;
          end else if (found_q) begin
            rp_d  = adv(rp_q, cap_q);
            cnt_d = cnt_q - COUNT_W'(1);
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        MODE_CLEAR: begin
          rp_d  = '0;
          wp_d  = '0;
          cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
    res.count = cnt_d;
  end

  // search and shift walk
  always_comb begin
    pos_d   = pos_q;
    idx_d   = idx_q;
    found_d = found_q;
    if (cmd_i.srch_start) begin
      pos_d   = rp_q;
      idx_d   = '0;
      found_d = 1'b0;
    end else if (cmd_i.srch_next) begin
      pos_d = adv(pos_q, cap_q);
      idx_d = idx_q + COUNT_W'(1);
    end else if (cmd_i.sh_wr) begin
      pos_d = pos_prev;
    end
    if (cmd_i.mark_found) begin
      found_d = 1'b1;
    end
  end

  assign out_valid_d = cmd_i.finish | (out_valid_q & out_stall_i);

  always_comb begin
    ram_re    = cmd_i.accept | cmd_i.srch_rd | cmd_i.sh_rd;
    ram_raddr = rp_q;
    if (cmd_i.srch_rd) begin
      ram_raddr = pos_q;
    end else if (cmd_i.sh_rd) begin
      ram_raddr = pos_prev;
    end
    ram_we    = push_we | cmd_i.sh_wr;
    ram_waddr = wp_q;
    ram_wdata = value_q;
    if (cmd_i.sh_wr) begin
      // move the older entry one place toward the tail
      ram_waddr = pos_q;
      ram_wdata = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RST;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q  <= in_data_i.mode;
      value_q <= in_data_i.value;
    end
    if (cmd_i.finish) begin
      out_q <= res;
    end
  end

  rfwr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.is_remove = (mode_q == MODE_REMOVE);
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.match     = (ram_rdata == value_q);
  assign sts_o.last      = ((idx_q + COUNT_W'(1)) == cnt_q);
  assign sts_o.at_head   = (pos_q == rp_q);
  assign sts_o.slot_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : rfwr_dp
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring FIFO with remove. A mirror of the FIFO
// predicts status, popped entry and count for every accepted request; each
// result is checked against the oldest prediction. Directed requests cover
// the empty, full and not-found cases, then random phases run at a range of
// capacities with bursty requests, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import rfwr_pkg::*;

  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned REPORT_LIMIT = 20;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_CLEAR + MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

  class fifo_mirror;
    logic [DATA_W-1:0]  slots [FIFO_DEPTH];
    int unsigned        rd_ptr;
    int unsigned        wr_ptr;
    int unsigned        fill;
    logic [COUNT_W-1:0] cap_reg;
    out_item_t          due_results [$];
    int unsigned        errors;

    function new();
      cap_reg = COUNT_W'(FIFO_DEPTH);
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      errors = 0;
    endfunction

    function int unsigned usable();
      if (cap_reg == 0) return 1;
      if (cap_reg > FIFO_DEPTH) return FIFO_DEPTH;
      return 32'(cap_reg);
    endfunction

    function int unsigned step(int unsigned p);
      return (p + 1 >= usable()) ? 0 : p + 1;
    endfunction

    function void empty_out();
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
    endfunction

    // a capacity write empties the FIFO as well
    function void write_capacity(logic [COUNT_W-1:0] v);
      cap_reg = v;
      empty_out();
    endfunction

    function void put(logic [DATA_W-1:0] v);
      slots[wr_ptr] = v;
      wr_ptr = step(wr_ptr);
      fill++;
    endfunction

    function logic [DATA_W-1:0] take();
      logic [DATA_W-1:0] v;
      v = slots[rd_ptr];
      rd_ptr = step(rd_ptr);
      fill--;
      return v;
    endfunction

    // k-th entry counted from the head
    function logic [DATA_W-1:0] held_entry(int unsigned k);
      return slots[(rd_ptr + k) % usable()];
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void note_request(in_item_t req);
      out_item_t   due;
      int unsigned lim;
      int          hit;
      due = '0;
      due.status = ST_OK;
      lim = usable();
      case (req.mode)
        MODE_PUSH: begin
          if (fill >= lim) due.status = ST_FULL;
          else put(req.value);
        end
        MODE_POP: begin
          if (fill == 0) due.status = ST_EMPTY;
          else due.popped = take();
        end
        MODE_POP_PUSH: begin
          if (fill == 0) due.status = ST_EMPTY;
          else due.popped = take();
          put(req.value);
        end
        MODE_REMOVE: begin
          if (fill == 0) begin
            due.status = ST_EMPTY;
          end else begin
            hit = -1;
            for (int k = 0; k < fill; k++) begin
              if (slots[(rd_ptr + k) % lim] == req.value) begin
                hit = k;
                break;
              end
            end
            if (hit < 0) begin
              due.status = ST_NOTFOUND;
            end else begin
              // move older entries one place towards the tail, drop the head
              for (int j = hit; j > 0; j--)
                slots[(rd_ptr + j) % lim] = slots[(rd_ptr + j - 1) % lim];
              rd_ptr = step(rd_ptr);
              fill--;
            end
          end
        end
        MODE_CLEAR: empty_out();
        default: ;
      endcase
      due.count = COUNT_W'(fill);
      due_results.push_back(due);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("MISMATCH: %s", msg);
    endtask

    task check_result(out_item_t got);
      out_item_t due;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: %p", got));
      end else begin
        due = due_results.pop_front();
        if (got.status !== due.status)
          report_mismatch($sformatf("status %0d, predicted %0d", got.status, due.status));
        if (got.popped !== due.popped)
          report_mismatch($sformatf("popped %h, predicted %h", got.popped, due.popped));
        if (got.count !== due.count)
          report_mismatch($sformatf("count %0d, predicted %0d", got.count, due.count));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_data;

  fifo_mirror         mirror;
  int unsigned        hold_left;
  logic [DATA_W-1:0]  value_pool [4];

  ring_fifo_with_remove #(
    .DEPTH(FIFO_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mirror.check_result(out_data);
  end

  // receiver: long hold-off when asked, otherwise stall at a rate that drifts
  initial begin
    int unsigned stall_pct;
    int unsigned pattern_left;
    int unsigned rates [4];
    rates = '{0, 25, 50, 85};
    stall_pct = 0;
    pattern_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        if (pattern_left == 0) begin
          stall_pct = rates[$urandom_range(0, 3)];
          pattern_left = $urandom_range(10, 150);
        end
        pattern_left--;
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int unsigned cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic in_item_t make_item(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
    in_item_t r;
    r.mode = mode;
    r.value = value;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return value_pool[$urandom_range(0, 3)];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t random_item(int unsigned push_pct);
    in_item_t    r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    r.value = pick_value();
    if (roll < 2) begin
      r.mode = MODE_CLEAR;
    end else if (roll < 5) begin
      r.mode = MODE_UNUSED_LO + MODE_W'($urandom_range(0, MODE_UNUSED_HI - MODE_UNUSED_LO));
    end else if (roll < 25) begin
      r.mode = MODE_REMOVE;
      // mostly aim at an entry that is actually held
      if (mirror.fill != 0 && $urandom_range(0, 3) != 0)
        r.value = mirror.held_entry($urandom_range(0, mirror.fill - 1));
    end else if (roll < 25 + push_pct) begin
      r.mode = MODE_PUSH;
    end else if (roll < 25 + push_pct + (75 - push_pct) / 2) begin
      r.mode = MODE_POP;
    end else begin
      r.mode = MODE_POP_PUSH;
    end
    return r;
  endfunction

  task automatic send_request(input in_item_t r);
    @(negedge clk);
    in_valid = 1'b1;
    in_data = r;
    do @(posedge clk); while (in_stall);
    mirror.note_request(r);
  endtask

  task automatic pause_sender(input int unsigned n);
    if (n != 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [COUNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(posedge clk);
    mirror.write_capacity(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_directed();
    logic [DATA_W-1:0] x, y, z;
    x = {$urandom, $urandom};
    y = {$urandom, $urandom};
    z = {$urandom, $urandom};
    // empty FIFO at the reset capacity
    send_request(make_item(MODE_POP, '0));
    send_request(make_item(MODE_REMOVE, x));
    send_request(make_item(MODE_POP_PUSH, '1));
    send_request(make_item(MODE_PUSH, '0));
    send_request(make_item(MODE_PUSH, x));
    send_request(make_item(MODE_PUSH, x));
    send_request(make_item(MODE_PUSH, y));
    send_request(make_item(MODE_REMOVE, x));
    send_request(make_item(MODE_REMOVE, z));
    send_request(make_item(MODE_POP, '0));
    send_request(make_item(MODE_POP_PUSH, z));
    send_request(make_item(MODE_UNUSED_LO, x));
    send_request(make_item(MODE_UNUSED_LO + MODE_W'(1), '0));
    send_request(make_item(MODE_UNUSED_HI, '1));
    send_request(make_item(MODE_REMOVE, y));
    send_request(make_item(MODE_CLEAR, '1));
    send_request(make_item(MODE_POP, '0));
    // zero capacity behaves as one entry
    write_capacity('0);
    send_request(make_item(MODE_PUSH, x));
    send_request(make_item(MODE_PUSH, y));
    send_request(make_item(MODE_POP_PUSH, z));
    send_request(make_item(MODE_REMOVE, z));
    send_request(make_item(MODE_POP_PUSH, y));
    send_request(make_item(MODE_POP, '0));
    drain();
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] cap, input int unsigned n_items,
                           input int unsigned push_pct, input bit steady);
    int unsigned burst_left;
    write_capacity(cap);
    burst_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        if (!steady) pause_sender($urandom_range(0, 8));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_request(random_item(push_pct));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_left = 0;
    mirror = new();
    for (int k = 0; k < 4; k++) value_pool[k] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    run_phase(COUNT_W'(127), 110, 45, 1'b0);
    run_phase(COUNT_W'(1), 100, 40, 1'b0);
    run_phase(COUNT_W'(5), 110, 35, 1'b1);
    // hold the receiver off while requests keep coming
    hold_left = 400;
    run_phase(COUNT_W'(64), 130, 55, 1'b1);
    run_phase(COUNT_W'(2), 100, 40, 1'b0);
    run_phase(COUNT_W'(65), 120, 50, 1'b0);
    run_phase(COUNT_W'(16), 110, 30, 1'b0);
    run_phase(COUNT_W'($urandom_range(1, 127)), 100, 40, 1'b0);

    drain();
    repeat (300) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rfwr_pkg.sv
sv/rfwr_ram.sv
sv/rfwr_ctrl.sv
sv/rfwr_dp.sv
sv/ring_fifo_with_remove.sv
tb/sv/tb_top.sv
